// ===== hdl/ffha_pkg.sv =====
// Shared codes, constants and sequencer states for the first-fit heap allocator.
package ffha_pkg;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_NO_MEM  = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	localparam logic [31:0] MIN_BLOCK  = 32'd16;
	localparam logic [31:0] TAG_ALLOC  = 32'd1;
	localparam logic [31:0] SIZE_MASK  = 32'hFFFF_FFF8;
	localparam logic [31:0] PRO_TAG    = 32'd9;
	localparam logic [31:0] HDR_OFF    = 32'd4;
	localparam logic [31:0] FTR_OFF    = 32'd8;
	localparam logic [31:0] FIRST_BP   = 32'd16;
	localparam logic [31:0] ROUND_ADD  = 32'd15;
	localparam logic [16:0] CHUNK_RST  = 17'd4096;
	localparam logic [16:0] CHUNK_MIN  = 17'd16;

	typedef enum logic [5:0] {
		S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_INIT3,
		S_ANEED, S_FF_CHK, S_FF_RD, S_FF_CAP, S_FF_NXT, S_FF_END,
		S_GSEL, S_G0, S_G1, S_G2, S_G3, S_G4,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_MA0, S_MA1, S_M5, S_M6,
		S_MN0, S_MN1, S_MB0, S_MB1, S_MT, S_MW, S_MRET,
		S_FR0, S_FR1, S_FR2, S_FR3, S_FR4,
		S_PUT0, S_PUT1, S_PS0, S_PS1, S_PS2, S_PS3, S_PS4, S_PS5,
		S_PN0, S_PN1, S_PN2, S_DONE
	} state_t;

endpackage

// ===== hdl/ffha_alu.sv =====
// Shared 32-bit adder/subtractor with unsigned borrow, used by the sequencer steps.
module ffha_alu (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic        sub,
	output logic [31:0] y,
	output logic        borrow
);

	logic [32:0] sum;

	always_comb begin
		if (sub) begin
			sum = {1'b0, a} - {1'b0, b};
		end else begin
			sum = {1'b0, a} + {1'b0, b};
		end
	end

	assign y      = sum[31:0];
	assign borrow = sub & sum[32];

endmodule

// ===== hdl/ffha_tag_ram.sv =====
// Single-port tag memory with registered read data.
module ffha_tag_ram #(
	parameter int DEPTH = 16384,
	parameter int IW    = 14,
	parameter int TW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] idx,
	input  logic [TW-1:0] wdata,
	output logic [TW-1:0] rdata
);

	logic [TW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx] <= wdata;
		end
		rdata <= mem[idx];
	end

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// Top level: boundary-tag first-fit heap allocator with sequencer and config port.
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  in      | in_valid, in_ready, operation, request_bytes,        | in
//          | block_address                                        |
//  out     | out_valid, out_ready, result_address, status         | out
//  apb     | psel, penable, pwrite, paddr, pwdata, prdata, pready | cfg
//
// One request at a time; init, free and allocate each run as a chain of sequencer
// states, an allocate visiting blocks one by one in its fit search and growing the heap
// when none fits, all bound by the single tag memory port and the shared adder.
// Reset clears the break and sets the chunk register to 4096; tag memory contents are not cleared.
// A finished result waits in the output register while the next request is taken.
module first_fit_heap_allocator #(
	parameter int HEAP_WORDS = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [19:0] request_bytes,
	input  logic [15:0] block_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_address,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(HEAP_WORDS);
	localparam int TW = IW + 3;
	localparam logic [31:0] HEAP_BYTES = 32'(HEAP_WORDS) * 32'd4;

	ffha_pkg::state_t state_q, state_d;

	logic [1:0]    op_q;
	logic [19:0]   req_q;
	logic [15:0]   addr_q;
	logic [16:0]   chunk_q;
	logic [TW-1:0] hend_q;
	logic [31:0]   bp_q, sz_q, psz_q, nsz_q, nx_q, prv_q, need_q, gs_q, u_q, t_q;
	logic          pu_q, nu_q, oob_q;
	logic [IW:0]   cnt_q;
	logic [1:0]    st_q;
	logic [15:0]   res_q;
	logic          out_valid_q;
	logic [15:0]   out_addr_q;
	logic [1:0]    out_st_q;

	logic [31:0]   alu_a, alu_b, alu_y;
	logic          alu_sub, alu_borrow;
	logic          mem_we;
	logic [31:0]   mem_wdata;
	logic [TW-1:0] ram_rdata;
	logic          oob_now;
	logic [31:0]   rtag, rsz, hend_x, chunk_eff, gs_raw;
	logic          cfg_wr, done_go;

	ffha_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.sub    (alu_sub),
		.y      (alu_y),
		.borrow (alu_borrow)
	);

	assign oob_now = (alu_y[31:2] >= 30'(HEAP_WORDS));

	ffha_tag_ram #(.DEPTH(HEAP_WORDS), .IW(IW), .TW(TW)) u_ram (
		.clk   (clk),
		.we    (mem_we & ~oob_now),
		.idx   (alu_y[IW+1:2]),
		.wdata (TW'(mem_wdata)),
		.rdata (ram_rdata)
	);

	// Out-of-store reads return zero
	assign rtag      = oob_q ? 32'd0 : 32'(ram_rdata);
	assign rsz       = rtag & ffha_pkg::SIZE_MASK;
	assign hend_x    = 32'(hend_q);
	assign chunk_eff = (chunk_q < ffha_pkg::CHUNK_MIN) ? 32'(ffha_pkg::CHUNK_MIN)
	                                                   : 32'(chunk_q);
	assign gs_raw    = (alu_y < ffha_pkg::MIN_BLOCK) ? ffha_pkg::MIN_BLOCK : alu_y;
	assign done_go   = ~out_valid_q | out_ready;

	// Config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr == 1'b0) ? 32'(chunk_q) : 32'd0;

	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_st_q;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		alu_a     = 32'd0;
		alu_b     = 32'd0;
		alu_sub   = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = 32'd0;
		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (operation)
						ffha_pkg::OP_INIT:  state_d = ffha_pkg::S_INIT0;
						ffha_pkg::OP_ALLOC: begin
							if (request_bytes == 20'd0 || hend_q == '0) begin
								state_d = ffha_pkg::S_DONE;
							end else begin
								state_d = ffha_pkg::S_ANEED;
							end
						end
						ffha_pkg::OP_FREE:  state_d = ffha_pkg::S_FR0;
						default:            state_d = ffha_pkg::S_DONE;
					endcase
				end
			end
			ffha_pkg::S_INIT0: begin
				mem_we = 1'b1;
				state_d = ffha_pkg::S_INIT1;
			end
			ffha_pkg::S_INIT1: begin
				alu_a = ffha_pkg::HDR_OFF; mem_we = 1'b1; mem_wdata = ffha_pkg::PRO_TAG;
				state_d = ffha_pkg::S_INIT2;
			end
			ffha_pkg::S_INIT2: begin
				alu_a = ffha_pkg::FTR_OFF; mem_we = 1'b1; mem_wdata = ffha_pkg::PRO_TAG;
				state_d = ffha_pkg::S_INIT3;
			end
			ffha_pkg::S_INIT3: begin
				alu_a = ffha_pkg::FTR_OFF + ffha_pkg::HDR_OFF;
				mem_we = 1'b1; mem_wdata = ffha_pkg::TAG_ALLOC;
				state_d = ffha_pkg::S_G0;
			end
			ffha_pkg::S_ANEED: begin
				alu_a = 32'(req_q); alu_b = ffha_pkg::ROUND_ADD;
				state_d = ffha_pkg::S_FF_CHK;
			end
			ffha_pkg::S_FF_CHK: begin
				alu_a = hend_x; alu_b = bp_q; alu_sub = 1'b1;
				if (alu_borrow || cnt_q == (IW+1)'(HEAP_WORDS)) begin
					state_d = ffha_pkg::S_GSEL;
				end else begin
					state_d = ffha_pkg::S_FF_RD;
				end
			end
			ffha_pkg::S_FF_RD: begin
				alu_a = bp_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				state_d = ffha_pkg::S_FF_CAP;
			end
			ffha_pkg::S_FF_CAP: begin
				alu_a = rsz; alu_b = need_q; alu_sub = 1'b1;
				priority if (rsz == 32'd0) begin
					state_d = ffha_pkg::S_GSEL;
				end else if (!rtag[0] && !alu_borrow) begin
					state_d = ffha_pkg::S_PUT0;
				end else begin
					state_d = ffha_pkg::S_FF_NXT;
				end
			end
			ffha_pkg::S_FF_NXT: begin
				alu_a = bp_q; alu_b = sz_q;
				state_d = ffha_pkg::S_FF_END;
			end
			ffha_pkg::S_FF_END: begin
				alu_a = hend_x; alu_b = t_q; alu_sub = 1'b1;
				state_d = alu_borrow ? ffha_pkg::S_GSEL : ffha_pkg::S_FF_CHK;
			end
			ffha_pkg::S_GSEL: begin
				alu_a = need_q; alu_b = chunk_eff; alu_sub = 1'b1;
				state_d = ffha_pkg::S_G0;
			end
			ffha_pkg::S_G0: begin
				// floor to words, round up to even word count
				alu_a = u_q & 32'hFFFF_FFFC; alu_b = u_q & 32'd4;
				state_d = ffha_pkg::S_G1;
			end
			ffha_pkg::S_G1: begin
				alu_a = hend_x; alu_b = gs_q;
				state_d = (alu_y > HEAP_BYTES) ? ffha_pkg::S_DONE : ffha_pkg::S_G2;
			end
			ffha_pkg::S_G2: begin
				alu_a = bp_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = gs_q;
				state_d = ffha_pkg::S_G3;
			end
			ffha_pkg::S_G3: begin
				alu_a = hend_x; alu_b = ffha_pkg::FTR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = gs_q;
				state_d = ffha_pkg::S_G4;
			end
			ffha_pkg::S_G4: begin
				alu_a = hend_x; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = ffha_pkg::TAG_ALLOC;
				state_d = ffha_pkg::S_M0;
			end
			ffha_pkg::S_M0: begin
				alu_a = bp_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				state_d = ffha_pkg::S_M1;
			end
			ffha_pkg::S_M1: begin
				alu_a = bp_q; alu_b = ffha_pkg::FTR_OFF; alu_sub = 1'b1;
				state_d = ffha_pkg::S_M2;
			end
			ffha_pkg::S_M2: begin
				alu_a = bp_q; alu_b = sz_q;
				state_d = ffha_pkg::S_M3;
			end
			ffha_pkg::S_M3: begin
				alu_a = nx_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				state_d = ffha_pkg::S_M4;
			end
			ffha_pkg::S_M4: begin
				alu_a = bp_q; alu_b = psz_q; alu_sub = 1'b1;
				priority if (pu_q && rtag[0]) begin
					state_d = ffha_pkg::S_MRET;
				end else if (pu_q) begin
					state_d = ffha_pkg::S_MA0;
				end else begin
					state_d = ffha_pkg::S_M5;
				end
			end
			ffha_pkg::S_MA0: begin
				alu_a = sz_q; alu_b = nsz_q;
				state_d = ffha_pkg::S_MA1;
			end
			ffha_pkg::S_MA1: begin
				alu_a = bp_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = u_q;
				state_d = ffha_pkg::S_MT;
			end
			ffha_pkg::S_M5: begin
				alu_a = prv_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				state_d = ffha_pkg::S_M6;
			end
			ffha_pkg::S_M6: begin
				alu_a = sz_q; alu_b = rsz;
				state_d = nu_q ? ffha_pkg::S_MN0 : ffha_pkg::S_MB0;
			end
			ffha_pkg::S_MN0: begin
				alu_a = nx_q; alu_b = ffha_pkg::FTR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = u_q;
				state_d = ffha_pkg::S_MN1;
			end
			ffha_pkg::S_MN1: begin
				alu_a = prv_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = u_q;
				state_d = ffha_pkg::S_MRET;
			end
			ffha_pkg::S_MB0: begin
				alu_a = u_q; alu_b = nsz_q;
				state_d = ffha_pkg::S_MB1;
			end
			ffha_pkg::S_MB1: begin
				alu_a = prv_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = u_q;
				state_d = ffha_pkg::S_MT;
			end
			ffha_pkg::S_MT: begin
				alu_a = nx_q; alu_b = nsz_q;
				state_d = ffha_pkg::S_MW;
			end
			ffha_pkg::S_MW: begin
				alu_a = t_q; alu_b = ffha_pkg::FTR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = u_q;
				state_d = ffha_pkg::S_MRET;
			end
			ffha_pkg::S_MRET: begin
				if (op_q == ffha_pkg::OP_ALLOC && bp_q != 32'd0) begin
					state_d = ffha_pkg::S_PUT0;
				end else begin
					state_d = ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_FR0: begin
				alu_a = 32'(addr_q); alu_b = hend_x; alu_sub = 1'b1;
				if (hend_q != '0 && addr_q[2:0] == 3'd0 && 32'(addr_q) >= ffha_pkg::FIRST_BP
				    && alu_borrow) begin
					state_d = ffha_pkg::S_FR1;
				end else begin
					state_d = ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_FR1: begin
				alu_a = bp_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				state_d = ffha_pkg::S_FR2;
			end
			ffha_pkg::S_FR2: begin
				alu_a = bp_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = rsz;
				state_d = ffha_pkg::S_FR3;
			end
			ffha_pkg::S_FR3: begin
				alu_a = bp_q; alu_b = sz_q;
				state_d = ffha_pkg::S_FR4;
			end
			ffha_pkg::S_FR4: begin
				alu_a = t_q; alu_b = ffha_pkg::FTR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = sz_q;
				state_d = ffha_pkg::S_M0;
			end
			ffha_pkg::S_PUT0: begin
				alu_a = bp_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				state_d = ffha_pkg::S_PUT1;
			end
			ffha_pkg::S_PUT1: begin
				alu_a = rsz; alu_b = need_q; alu_sub = 1'b1;
				// wrapped difference counts as large, as in unsigned math
				state_d = (alu_y >= ffha_pkg::MIN_BLOCK) ? ffha_pkg::S_PS0 : ffha_pkg::S_PN0;
			end
			ffha_pkg::S_PS0: begin
				alu_a = bp_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = need_q | ffha_pkg::TAG_ALLOC;
				state_d = ffha_pkg::S_PS1;
			end
			ffha_pkg::S_PS1: begin
				alu_a = bp_q; alu_b = need_q;
				state_d = ffha_pkg::S_PS2;
			end
			ffha_pkg::S_PS2: begin
				alu_a = t_q; alu_b = ffha_pkg::FTR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = need_q | ffha_pkg::TAG_ALLOC;
				state_d = ffha_pkg::S_PS3;
			end
			ffha_pkg::S_PS3: begin
				alu_a = t_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = u_q;
				state_d = ffha_pkg::S_PS4;
			end
			ffha_pkg::S_PS4: begin
				alu_a = t_q; alu_b = u_q;
				state_d = ffha_pkg::S_PS5;
			end
			ffha_pkg::S_PS5: begin
				alu_a = t_q; alu_b = ffha_pkg::FTR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = u_q;
				state_d = ffha_pkg::S_DONE;
			end
			ffha_pkg::S_PN0: begin
				alu_a = bp_q; alu_b = ffha_pkg::HDR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = sz_q | ffha_pkg::TAG_ALLOC;
				state_d = ffha_pkg::S_PN1;
			end
			ffha_pkg::S_PN1: begin
				alu_a = bp_q; alu_b = sz_q;
				state_d = ffha_pkg::S_PN2;
			end
			ffha_pkg::S_PN2: begin
				alu_a = t_q; alu_b = ffha_pkg::FTR_OFF; alu_sub = 1'b1;
				mem_we = 1'b1; mem_wdata = sz_q | ffha_pkg::TAG_ALLOC;
				state_d = ffha_pkg::S_DONE;
			end
			ffha_pkg::S_DONE: begin
				if (done_go) begin
					state_d = ffha_pkg::S_IDLE;
				end
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffha_pkg::S_IDLE;
			hend_q      <= '0;
			chunk_q     <= ffha_pkg::CHUNK_RST;
			out_valid_q <= 1'b0;
			st_q        <= ffha_pkg::ST_OK;
			res_q       <= '0;
			cnt_q       <= '0;
			oob_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			oob_q   <= oob_now;
			if (cfg_wr && paddr == 1'b0) begin
				chunk_q <= pwdata[16:0];
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ffha_pkg::S_IDLE: begin
					if (in_valid) begin
						st_q  <= ffha_pkg::ST_OK;
						res_q <= '0;
						if (operation == ffha_pkg::OP_ALLOC) begin
							if (request_bytes == 20'd0) begin
								st_q <= ffha_pkg::ST_ZERO;
							end else if (hend_q == '0) begin
								st_q <= ffha_pkg::ST_NO_MEM;
							end
						end
					end
				end
				ffha_pkg::S_INIT3: hend_q <= TW'(ffha_pkg::FIRST_BP);
				ffha_pkg::S_ANEED: cnt_q <= '0;
				ffha_pkg::S_FF_END: begin
					if (!alu_borrow) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ffha_pkg::S_G1: begin
					if (alu_y > HEAP_BYTES) begin
						st_q <= ffha_pkg::ST_NO_MEM;
					end else begin
						hend_q <= TW'(alu_y);
					end
				end
				ffha_pkg::S_MRET: begin
					if (op_q == ffha_pkg::OP_ALLOC && bp_q == 32'd0) begin
						st_q <= ffha_pkg::ST_NO_MEM;
					end
				end
				ffha_pkg::S_PS5, ffha_pkg::S_PN2: res_q <= bp_q[15:0];
				ffha_pkg::S_DONE: begin
					if (done_go) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ffha_pkg::S_DONE && done_go) begin
			out_addr_q <= res_q;
			out_st_q   <= st_q;
		end
		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				if (in_valid) begin
					op_q   <= operation;
					req_q  <= request_bytes;
					addr_q <= block_address;
				end
			end
			ffha_pkg::S_INIT3: u_q <= chunk_eff;
			ffha_pkg::S_ANEED: begin
				need_q <= alu_y & ffha_pkg::SIZE_MASK;
				bp_q   <= ffha_pkg::FIRST_BP;
			end
			ffha_pkg::S_FF_CAP: sz_q <= rsz;
			ffha_pkg::S_FF_NXT: t_q <= alu_y;
			ffha_pkg::S_FF_END: bp_q <= t_q;
			ffha_pkg::S_GSEL:   u_q <= alu_borrow ? chunk_eff : need_q;
			ffha_pkg::S_G0:     gs_q <= gs_raw;
			ffha_pkg::S_G1:     bp_q <= hend_x;
			ffha_pkg::S_M1:     sz_q <= rsz;
			ffha_pkg::S_M2: begin
				psz_q <= rsz;
				pu_q  <= rtag[0];
				nx_q  <= alu_y;
			end
			ffha_pkg::S_M4: begin
				nu_q  <= rtag[0];
				nsz_q <= rsz;
				prv_q <= alu_y;
			end
			ffha_pkg::S_MA0, ffha_pkg::S_M6, ffha_pkg::S_MB0: u_q <= alu_y;
			ffha_pkg::S_MN1, ffha_pkg::S_MB1: bp_q <= prv_q;
			ffha_pkg::S_MT:     t_q <= alu_y;
			ffha_pkg::S_FR0:    bp_q <= 32'(addr_q);
			ffha_pkg::S_FR2:    sz_q <= rsz;
			ffha_pkg::S_FR3:    t_q <= alu_y;
			ffha_pkg::S_PUT1: begin
				sz_q <= rsz;
				u_q  <= alu_y;
			end
			ffha_pkg::S_PS1, ffha_pkg::S_PS4, ffha_pkg::S_PN1: t_q <= alu_y;
			default: ;
		endcase
	end

endmodule

// ===== tb/sv/first_fit_heap_allocator_tb.sv =====
// Self-checking testbench for the first-fit heap allocator: directed table, then random requests.
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam int WORDS = 16384;

	typedef struct {
		logic [15:0] addr;
		status_t     st;
	} alloc_result_t;

	typedef struct {
		op_t         op;
		logic [19:0] req;
		logic [15:0] addr;
		bit          typed;
		logic [15:0] eaddr;
		status_t     est;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [19:0] request_bytes;
	logic [15:0] block_address;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] result_address;
	logic [1:0]  status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// heap shadow: tags, which words were ever written, break and chunk size
	bit [31:0]     tag_mem [WORDS];
	bit            tag_set [WORDS];
	bit [31:0]     mem_bak [WORDS];
	bit            set_bak [WORDS];
	bit [31:0]     brk;
	bit [31:0]     brk_bak;
	bit [16:0]     chunk_reg;
	bit            stray_read;
	bit            heap_clean;
	bit            clean_bak;
	int            live_blocks[$];
	int            live_bak[$];
	alloc_result_t pending_q[$];
	alloc_result_t got_exp;
	int            errors;
	bit            no_idle;
	bit            hold_go;

	first_fit_heap_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .request_bytes(request_bytes), .block_address(block_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_address(result_address), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit [31:0] tag_rd(input bit [31:0] a);
		bit [31:0] i;
		i = a >> 2;
		if (i >= WORDS)
			return 0;
		if (!tag_set[i])
			stray_read = 1'b1;
		return tag_mem[i];
	endfunction

	function automatic void tag_wr(input bit [31:0] a, input bit [31:0] v);
		bit [31:0] i;
		i = a >> 2;
		if (i < WORDS) begin
			tag_mem[i] = v;
			tag_set[i] = 1'b1;
		end
	endfunction

	function automatic bit [31:0] blk_bytes(input bit [31:0] bp);
		return tag_rd(bp - 4) & SIZE_MASK;
	endfunction

	function automatic bit [31:0] coalesce(input bit [31:0] bp);
		bit [31:0] sz, pt, nt, nxt, prv, nsz;
		sz = blk_bytes(bp);
		pt = tag_rd(bp - 8);
		prv = bp - (pt & SIZE_MASK);
		nxt = bp + sz;
		nt = tag_rd(nxt - 4);
		if (pt[0] && nt[0])
			return bp;
		if (pt[0]) begin
			sz += blk_bytes(nxt);
			tag_wr(bp - 4, sz);
			tag_wr(bp + sz - 8, sz);
			return bp;
		end
		if (nt[0]) begin
			sz += blk_bytes(prv);
			tag_wr(bp + blk_bytes(bp) - 8, sz);
			tag_wr(prv - 4, sz);
			return prv;
		end
		nsz = blk_bytes(nxt);
		sz += blk_bytes(prv) + nsz;
		tag_wr(prv - 4, sz);
		tag_wr(nxt + nsz - 8, sz);
		return prv;
	endfunction

	function automatic bit [31:0] extend_heap(input bit [31:0] bytes);
		bit [31:0] words, sz, bp;
		words = bytes >> 2;
		if (words[0])
			words++;
		sz = words * 4;
		if (sz < 16)
			sz = 16;
		if (64'(brk) + sz > 64'(WORDS) * 4)
			return 0;
		bp = brk;
		brk += sz;
		tag_wr(bp - 4, sz);
		tag_wr(bp + sz - 8, sz);
		tag_wr(bp + sz - 4, TAG_ALLOC);
		return coalesce(bp);
	endfunction

	function automatic bit [31:0] find_fit(input bit [31:0] need);
		bit [31:0] bp, h, sz;
		bp = 16;
		for (int n = 0; n < WORDS; n++) begin
			if (bp > brk)
				break;
			h = tag_rd(bp - 4);
			sz = h & SIZE_MASK;
			if (sz == 0)
				break;
			if (!h[0] && sz >= need)
				return bp;
			if (33'(bp) + sz > 33'(brk))
				break;
			bp += sz;
		end
		return 0;
	endfunction

	function automatic void place_block(input bit [31:0] bp, input bit [31:0] need);
		bit [31:0] have, rest;
		have = blk_bytes(bp);
		if (have - need >= 16) begin
			rest = have - need;
			tag_wr(bp - 4, need | TAG_ALLOC);
			tag_wr(bp + need - 8, need | TAG_ALLOC);
			tag_wr(bp + need - 4, rest);
			tag_wr(bp + need + rest - 8, rest);
		end else begin
			tag_wr(bp - 4, have | TAG_ALLOC);
			tag_wr(bp + have - 8, have | TAG_ALLOC);
		end
	endfunction

	function automatic alloc_result_t heap_step(input op_t op, input bit [19:0] req,
			input bit [15:0] addr);
		alloc_result_t r;
		bit [31:0] chunk, need, bp, sz;
		bit found;
		r.addr = '0;
		r.st = ST_OK;
		chunk = (chunk_reg < 16) ? 16 : chunk_reg;
		case (op)
			OP_INIT: begin
				tag_wr(0, 0);
				tag_wr(4, 8 | TAG_ALLOC);
				tag_wr(8, 8 | TAG_ALLOC);
				tag_wr(12, TAG_ALLOC);
				brk = 16;
				live_blocks.delete();
				heap_clean = 1'b1;
				if (extend_heap(chunk) == 0)
					r.st = ST_NO_MEM;
			end
			OP_ALLOC: begin
				if (req == 0)
					r.st = ST_ZERO;
				else if (brk == 0)
					r.st = ST_NO_MEM;
				else begin
					need = (req <= 8) ? 16 : 8 * ((32'(req) + 15) / 8);
					bp = find_fit(need);
					if (bp == 0)
						bp = extend_heap(need > chunk ? need : chunk);
					if (bp == 0)
						r.st = ST_NO_MEM;
					else begin
						place_block(bp, need);
						r.addr = bp[15:0];
						live_blocks.push_back(int'(bp));
					end
				end
			end
			OP_FREE: begin
				if (brk != 0 && addr[2:0] == 0 && addr >= 16 && 32'(addr) < brk) begin
					found = 1'b0;
					foreach (live_blocks[i])
						if (!found && live_blocks[i] == int'(addr)) begin
							live_blocks.delete(i);
							found = 1'b1;
						end
					if (!found)
						heap_clean = 1'b0;
					sz = blk_bytes(addr);
					tag_wr(addr - 4, sz);
					tag_wr(addr + sz - 8, sz);
					void'(coalesce(addr));
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_req(input op_t op, input bit [19:0] req, input bit [15:0] addr);
		if (!no_idle)
			while ($urandom_range(99) < 11) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		operation <= op;
		request_bytes <= req;
		block_address <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_chunk(input bit [16:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 1'b0;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		chunk_reg = v;
	endtask

	task automatic random_req();
		op_t op;
		bit [19:0] req;
		bit [15:0] addr;
		int r;
		alloc_result_t e;
		op = OP_ALLOC;
		r = $urandom_range(99);
		req = $urandom_range(20'hFFFFF);
		addr = $urandom_range(16'hFFFF);
		if (r < 1)
			op = OP_INIT;
		else if (r < 60) begin
			r = $urandom_range(99);
			if (r < 10) req = $urandom_range(8, 1);
			else if (r < 60) req = $urandom_range(128, 9);
			else if (r < 85) req = $urandom_range(2048, 129);
			else if (r < 93) req = $urandom_range(20000, 2049);
			else if (r < 96) req = 0;
		end else if (r < 93) begin
			op = OP_FREE;
			if (live_blocks.size() != 0)
				addr = live_blocks[$urandom_range(live_blocks.size() - 1)];
		end else if (r < 96)
			op = OP_FREE;
		else if (r < 98) begin
			// stray free: an aligned address inside the heap that may not be a block
			op = OP_FREE;
			addr = (brk > 16) ? ($urandom_range(brk - 1, 16) & 32'hFFF8) : 16'd16;
		end else
			op = OP_NONE;
		if (!heap_clean || op == OP_FREE) begin
			mem_bak = tag_mem;
			set_bak = tag_set;
			brk_bak = brk;
			live_bak = live_blocks;
			clean_bak = heap_clean;
		end
		stray_read = 1'b0;
		e = heap_step(op, req, addr);
		// a request that would touch never-written tag words is swapped for a no-op
		if (stray_read) begin
			tag_mem = mem_bak;
			tag_set = set_bak;
			brk = brk_bak;
			live_blocks = live_bak;
			heap_clean = clean_bak;
			op = OP_NONE;
			e = heap_step(op, req, addr);
		end
		pending_q.push_back(e);
		send_req(op, req, addr);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_go = 1'b0;
			end else
				out_ready <= no_idle || ($urandom_range(99) >= 11);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result addr=%0d status=%0d", $time,
					result_address, status);
			end else begin
				got_exp = pending_q.pop_front();
				if (result_address !== got_exp.addr) begin
					errors++;
					$display("%0t: result_address expected %0d actual %0d", $time,
						got_exp.addr, result_address);
				end
				if (status !== got_exp.st) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time,
						got_exp.st, status);
				end
			end
		end
	end

	initial begin
		#400000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		dir_row_t rows[$];
		alloc_result_t e;
		bit [16:0] chunks[8];
		int counts[8];
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_NONE;
		request_bytes = '0;
		block_address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		no_idle = 1'b0;
		hold_go = 1'b0;
		brk = 0;
		chunk_reg = CHUNK_RST;
		heap_clean = 1'b1;
		chunks = '{17'd4096, 17'd16, 17'd65536, 17'd0, 17'd17, 17'd65520, 17'd300, 17'd1000};
		counts = '{300, 300, 40, 250, 250, 120, 300, 300};

		rows.push_back('{OP_ALLOC, 20'd5,     16'd0,      1, 16'd0,  ST_NO_MEM});
		rows.push_back('{OP_ALLOC, 20'd0,     16'd0,      1, 16'd0,  ST_ZERO});
		rows.push_back('{OP_FREE,  20'd0,     16'd16,     1, 16'd0,  ST_OK});
		rows.push_back('{OP_NONE,  20'hFFFFF, 16'hFFFF,   1, 16'd0,  ST_OK});
		rows.push_back('{OP_INIT,  20'd0,     16'd0,      1, 16'd0,  ST_OK});
		rows.push_back('{OP_ALLOC, 20'd1,     16'd0,      1, 16'd16, ST_OK});
		rows.push_back('{OP_ALLOC, 20'd0,     16'd0,      1, 16'd0,  ST_ZERO});
		rows.push_back('{OP_ALLOC, 20'd8,     16'd0,      1, 16'd32, ST_OK});
		rows.push_back('{OP_ALLOC, 20'd9,     16'd0,      1, 16'd48, ST_OK});
		rows.push_back('{OP_FREE,  20'd0,     16'd32,     1, 16'd0,  ST_OK});
		rows.push_back('{OP_FREE,  20'd0,     16'd33,     1, 16'd0,  ST_OK});
		rows.push_back('{OP_FREE,  20'd0,     16'd8,      1, 16'd0,  ST_OK});
		rows.push_back('{OP_FREE,  20'd0,     16'hFFF8,   1, 16'd0,  ST_OK});
		rows.push_back('{OP_ALLOC, 20'hFFFFF, 16'd0,      1, 16'd0,  ST_NO_MEM});
		rows.push_back('{OP_ALLOC, 20'd16,    16'd0,      0, 16'd0,  ST_OK});
		rows.push_back('{OP_ALLOC, 20'd4000,  16'd0,      0, 16'd0,  ST_OK});
		rows.push_back('{OP_FREE,  20'd0,     16'd16,     1, 16'd0,  ST_OK});
		rows.push_back('{OP_FREE,  20'd0,     16'd48,     1, 16'd0,  ST_OK});
		rows.push_back('{OP_ALLOC, 20'd8,     16'd0,      0, 16'd0,  ST_OK});
		rows.push_back('{OP_INIT,  20'd0,     16'd0,      1, 16'd0,  ST_OK});
		rows.push_back('{OP_ALLOC, 20'd4080,  16'd0,      0, 16'd0,  ST_OK});
		rows.push_back('{OP_ALLOC, 20'd65000, 16'd0,      0, 16'd0,  ST_OK});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			e = heap_step(rows[i].op, rows[i].req, rows[i].addr);
			if (rows[i].typed) begin
				e.addr = rows[i].eaddr;
				e.st = rows[i].est;
			end
			pending_q.push_back(e);
			send_req(rows[i].op, rows[i].req, rows[i].addr);
		end

		for (int p = 0; p < 8; p++) begin
			drain_results();
			repeat (4) @(posedge clk);
			write_chunk(chunks[p]);
			no_idle = (p == 1);
			pending_q.push_back(heap_step(OP_INIT, '0, '0));
			send_req(OP_INIT, '0, '0);
			for (int k = 0; k < counts[p]; k++) begin
				if (p == 0 && k == 100)
					hold_go = 1'b1;
				if (k % 150 == 149)
					drain_results();
				random_req();
			end
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== first_fit_heap_allocator.f =====
hdl/ffha_pkg.sv
hdl/ffha_alu.sv
hdl/ffha_tag_ram.sv
hdl/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_tb.sv
